### rtl/core/psd_pkg.sv
// package: shared constants and types for the point to segment distance core
`default_nettype none
package psd_pkg;

  // default coordinate width
  localparam int COORD_BITS_DEF = 32;
  // fraction bits of the projection parameter
  localparam int T_FRAC = 32;

  // nearest point class of an item
  typedef enum logic [2:0] {
    SEL_START = 3'b001,
    SEL_END   = 3'b010,
    SEL_FOOT  = 3'b100
  } sel_t;

endpackage
`default_nettype wire

### rtl/core/point_segment_distance_core.sv
// top level: fully pipelined point to segment distance, one item per cycle
// pipeline: the projection divider has 32 stages and the root has COORD_BITS+3 stages
// throughput: one item per cycle, busy is never raised
// reset: synchronous, active low, clears the valid bits of every stage; data is not reset
// results are shown for one cycle under out_valid, the receiver cannot stall
`default_nettype none
module point_segment_distance_core #(
  parameter int COORD_BITS = psd_pkg::COORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic signed [COORD_BITS-1:0] in_point_x,
  input  wire logic signed [COORD_BITS-1:0] in_point_y,
  input  wire logic signed [COORD_BITS-1:0] in_start_x,
  input  wire logic signed [COORD_BITS-1:0] in_start_y,
  input  wire logic signed [COORD_BITS-1:0] in_end_x,
  input  wire logic signed [COORD_BITS-1:0] in_end_y,
  output logic                              out_valid,
  output logic             [COORD_BITS:0]   out_distance
);

  localparam int N   = COORD_BITS;
  localparam int DW  = 2*N + 4;          // dot product and divider remainder
  localparam int LW  = 2*N + 3;          // squared length
  localparam int TF  = psd_pkg::T_FRAC;
  localparam int PW  = N + 1 + TF;       // t times direction
  localparam int VW  = N + 3;            // difference vector to nearest point
  localparam int W   = 2*N + 6;          // root radicand
  localparam int H   = N + 3;            // root bits
  localparam int RQ  = H + 4;            // root remainder

  assign busy = 1'b0;

  // stage 1: differences
  logic                v1_r;
  logic signed [N:0]   dx1_r, dy1_r, ax1_r, ay1_r, bx1_r, by1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start;
    end
    dx1_r <= $signed({in_end_x[N-1], in_end_x}) - $signed({in_start_x[N-1], in_start_x});
    dy1_r <= $signed({in_end_y[N-1], in_end_y}) - $signed({in_start_y[N-1], in_start_y});
    ax1_r <= $signed({in_point_x[N-1], in_point_x}) - $signed({in_start_x[N-1], in_start_x});
    ay1_r <= $signed({in_point_y[N-1], in_point_y}) - $signed({in_start_y[N-1], in_start_y});
    bx1_r <= $signed({in_point_x[N-1], in_point_x}) - $signed({in_end_x[N-1], in_end_x});
    by1_r <= $signed({in_point_y[N-1], in_point_y}) - $signed({in_end_y[N-1], in_end_y});
  end

  // stage 2: products of magnitudes
  logic [N:0] mdx1, mdy1, max1, may1;
  assign mdx1 = dx1_r[N] ? (N+1)'(0) - dx1_r : dx1_r;
  assign mdy1 = dy1_r[N] ? (N+1)'(0) - dy1_r : dy1_r;
  assign max1 = ax1_r[N] ? (N+1)'(0) - ax1_r : ax1_r;
  assign may1 = ay1_r[N] ? (N+1)'(0) - ay1_r : ay1_r;

  logic                v2_r, negx2_r, negy2_r, degen2_r;
  logic [2*N+1:0]      pxx2_r, pyy2_r, lxx2_r, lyy2_r;
  logic signed [N:0]   dx2_r, dy2_r, ax2_r, ay2_r, bx2_r, by2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    pxx2_r   <= max1 * mdx1;
    pyy2_r   <= may1 * mdy1;
    lxx2_r   <= mdx1 * mdx1;
    lyy2_r   <= mdy1 * mdy1;
    negx2_r  <= ax1_r[N] ^ dx1_r[N];
    negy2_r  <= ay1_r[N] ^ dy1_r[N];
    degen2_r <= (dx1_r == '0) && (dy1_r == '0);
    dx2_r <= dx1_r; dy2_r <= dy1_r; ax2_r <= ax1_r;
    ay2_r <= ay1_r; bx2_r <= bx1_r; by2_r <= by1_r;
  end

  // stage 3: signed dot product and squared length
  logic signed [DW-1:0] tx2, ty2;
  assign tx2 = negx2_r ? -$signed(DW'(pxx2_r)) : $signed(DW'(pxx2_r));
  assign ty2 = negy2_r ? -$signed(DW'(pyy2_r)) : $signed(DW'(pyy2_r));

  logic                 v3_r, degen3_r;
  logic signed [DW-1:0] dot3_r;
  logic [LW-1:0]        len3_r;
  logic signed [N:0]    dx3_r, dy3_r, ax3_r, ay3_r, bx3_r, by3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    dot3_r   <= tx2 + ty2;
    len3_r   <= LW'(lxx2_r) + LW'(lyy2_r);
    degen3_r <= degen2_r;
    dx3_r <= dx2_r; dy3_r <= dy2_r; ax3_r <= ax2_r;
    ay3_r <= ay2_r; bx3_r <= bx2_r; by3_r <= by2_r;
  end

  // stage 4: classify and load the divider
  psd_pkg::sel_t sel3;
  always_comb begin
    if (degen3_r || dot3_r <= 0) begin
      sel3 = psd_pkg::SEL_START;
    end else if ($unsigned(dot3_r) >= DW'(len3_r)) begin
      sel3 = psd_pkg::SEL_END;
    end else begin
      sel3 = psd_pkg::SEL_FOOT;
    end
  end

  // divider stage arrays, index 0 is the load stage
  logic               dv_r   [TF+1];
  psd_pkg::sel_t      dsel_r [TF+1];
  logic [DW-1:0]      drem_r [TF+1];
  logic [LW-1:0]      dlen_r [TF+1];
  logic [TF-1:0]      dt_r   [TF+1];
  logic signed [N:0]  ddx_r  [TF+1];
  logic signed [N:0]  ddy_r  [TF+1];
  logic signed [N:0]  dax_r  [TF+1];
  logic signed [N:0]  day_r  [TF+1];
  logic signed [N:0]  dbx_r  [TF+1];
  logic signed [N:0]  dby_r  [TF+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else begin
      dv_r[0] <= v3_r;
    end
    dsel_r[0] <= sel3;
    drem_r[0] <= (sel3 == psd_pkg::SEL_FOOT) ? $unsigned(dot3_r) : '0;
    dlen_r[0] <= len3_r;
    dt_r[0]   <= '0;
    ddx_r[0] <= dx3_r; ddy_r[0] <= dy3_r; dax_r[0] <= ax3_r;
    day_r[0] <= ay3_r; dbx_r[0] <= bx3_r; dby_r[0] <= by3_r;
  end

  // divider: one quotient bit per stage
  for (genvar k = 0; k < TF; k++) begin : g_div
    logic [DW-1:0] rem2;
    logic          ge;
    assign rem2 = {drem_r[k][DW-2:0], 1'b0};
    assign ge   = rem2 >= DW'(dlen_r[k]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k+1] <= 1'b0;
      end else begin
        dv_r[k+1] <= dv_r[k];
      end
      drem_r[k+1] <= ge ? rem2 - DW'(dlen_r[k]) : rem2;
      dt_r[k+1]   <= {dt_r[k][TF-2:0], ge};
      dsel_r[k+1] <= dsel_r[k];
      dlen_r[k+1] <= dlen_r[k];
      ddx_r[k+1] <= ddx_r[k]; ddy_r[k+1] <= ddy_r[k]; dax_r[k+1] <= dax_r[k];
      day_r[k+1] <= day_r[k]; dbx_r[k+1] <= dbx_r[k]; dby_r[k+1] <= dby_r[k];
    end
  end

  // stage m1: t times direction magnitude
  logic [N:0] mdxd, mdyd;
  assign mdxd = ddx_r[TF][N] ? (N+1)'(0) - ddx_r[TF] : ddx_r[TF];
  assign mdyd = ddy_r[TF][N] ? (N+1)'(0) - ddy_r[TF] : ddy_r[TF];

  logic              vm1_r, ndx_m1_r, ndy_m1_r;
  psd_pkg::sel_t     selm1_r;
  logic [PW-1:0]     prx_m1_r, pry_m1_r;
  logic signed [N:0] axm1_r, aym1_r, bxm1_r, bym1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm1_r <= 1'b0;
    end else begin
      vm1_r <= dv_r[TF];
    end
    prx_m1_r <= dt_r[TF] * mdxd;
    pry_m1_r <= dt_r[TF] * mdyd;
    ndx_m1_r <= ddx_r[TF][N];
    ndy_m1_r <= ddy_r[TF][N];
    selm1_r  <= dsel_r[TF];
    axm1_r <= dax_r[TF]; aym1_r <= day_r[TF]; bxm1_r <= dbx_r[TF]; bym1_r <= dby_r[TF];
  end

  // stage m2: floored offset, vector to the nearest point
  logic signed [N+1:0] offx, offy;
  logic signed [VW-1:0] fx, fy;
  logic signed [VW-1:0] vx, vy;
  always_comb begin
    offx = $signed({1'b0, prx_m1_r[PW-1:TF]});
    offy = $signed({1'b0, pry_m1_r[PW-1:TF]});
    if (ndx_m1_r) offx = -offx - $signed((N+2)'(prx_m1_r[TF-1:0] != '0));
    if (ndy_m1_r) offy = -offy - $signed((N+2)'(pry_m1_r[TF-1:0] != '0));
    fx = VW'(axm1_r) - VW'(offx);
    fy = VW'(aym1_r) - VW'(offy);
    case (selm1_r)
      psd_pkg::SEL_END: begin
        vx = VW'(bxm1_r);
        vy = VW'(bym1_r);
      end
      psd_pkg::SEL_FOOT: begin
        vx = fx;
        vy = fy;
      end
      default: begin
        vx = VW'(axm1_r);
        vy = VW'(aym1_r);
      end
    endcase
  end

  logic                 vm2_r;
  logic signed [VW-1:0] vxm2_r, vym2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm2_r <= 1'b0;
    end else begin
      vm2_r <= vm1_r;
    end
    vxm2_r <= vx;
    vym2_r <= vy;
  end

  // stage q1: squares
  logic [VW-1:0] mvx, mvy;
  assign mvx = vxm2_r[VW-1] ? VW'(0) - vxm2_r : vxm2_r;
  assign mvy = vym2_r[VW-1] ? VW'(0) - vym2_r : vym2_r;

  logic         vq1_r;
  logic [W-1:0] sqx_q1_r, sqy_q1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vq1_r <= 1'b0;
    end else begin
      vq1_r <= vm2_r;
    end
    sqx_q1_r <= mvx * mvx;
    sqy_q1_r <= mvy * mvy;
  end

  // root stage arrays, index 0 holds the radicand
  logic          sv_r    [H+1];
  logic [W-1:0]  srad_r  [H+1];
  logic [RQ-1:0] srem_r  [H+1];
  logic [H-1:0]  sroot_r [H+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r[0] <= 1'b0;
    end else begin
      sv_r[0] <= vq1_r;
    end
    srad_r[0]  <= sqx_q1_r + sqy_q1_r;
    srem_r[0]  <= '0;
    sroot_r[0] <= '0;
  end

  // square root: one root bit per stage
  for (genvar j = 0; j < H; j++) begin : g_sqrt
    logic [RQ-1:0] r2, trial;
    logic          ge;
    assign r2    = {srem_r[j][RQ-3:0], srad_r[j][W-1:W-2]};
    assign trial = {(RQ-2)'(sroot_r[j]), 2'b01};
    assign ge    = r2 >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[j+1] <= 1'b0;
      end else begin
        sv_r[j+1] <= sv_r[j];
      end
      srad_r[j+1]  <= {srad_r[j][W-3:0], 2'b00};
      srem_r[j+1]  <= ge ? r2 - trial : r2;
      sroot_r[j+1] <= {sroot_r[j][H-2:0], ge};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= sv_r[H];
    end
    out_distance <= sroot_r[H][N:0];
  end

  // reset empties the pipe: no result in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  // a foot item leaves the divider with a proper remainder
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    dv_r[TF] && dsel_r[TF] == psd_pkg::SEL_FOOT |-> drem_r[TF] < DW'(dlen_r[TF]))
    else $error("divider remainder not below squared length");

  // root remainder never exceeds twice the partial root
  a_sqrt_rem: assert property (@(posedge clk) disable iff (!rst_n)
    sv_r[H] |-> srem_r[H] <= {(RQ-1)'(sroot_r[H]), 1'b0})
    else $error("square root remainder out of range");

endmodule
`default_nettype wire

### bench/tb_point_segment_distance_core.sv
// testbench: point to segment distance core against an exact integer predictor
`default_nettype none
module tb_point_segment_distance_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = psd_pkg::COORD_BITS_DEF;
  localparam int N_RANDOM = 1330;
  localparam int LATENCY = CB + 44;
  localparam longint CYCLE_LIMIT = 400000;

  typedef logic signed [CB-1:0] coord_t;
  typedef logic [CB:0] dist_t;

  typedef struct {
    coord_t px, py, sx, sy, ex, ey;
    logic   known;
    dist_t  exp_dist;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  coord_t in_point_x = '0, in_point_y = '0, in_start_x = '0;
  coord_t in_start_y = '0, in_end_x = '0, in_end_y = '0;
  logic out_valid;
  dist_t out_distance;

  dist_t pending_dist[$];
  int fail_count = 0;
  longint cycle_count = 0;

  point_segment_distance_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_point_x(in_point_x), .in_point_y(in_point_y),
    .in_start_x(in_start_x), .in_start_y(in_start_y),
    .in_end_x(in_end_x), .in_end_y(in_end_y),
    .out_valid(out_valid), .out_distance(out_distance)
  );

  always #5 clk = ~clk;

  // floor of the square root of a wide unsigned value
  function automatic logic [63:0] isqrt(input logic [129:0] v);
    logic [63:0] root;
    logic [63:0] cand;
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if ({66'd0, cand} * {66'd0, cand} <= v) root = cand;
    end
    return root;
  endfunction

  function automatic logic [63:0] hypot_floor(input logic signed [65:0] a,
                                              input logic signed [65:0] b);
    logic signed [131:0] s;
    s = a * a + b * b;
    return isqrt(s[129:0]);
  endfunction

  // expected distance from point to segment
  function automatic dist_t seg_distance(input coord_t px, py, sx, sy, ex, ey);
    logic signed [65:0] dx, dy, ax, ay, hx, hy;
    logic signed [131:0] dot, len2, prod;
    logic [131:0] num;
    logic [31:0] t;
    dx = 66'(ex) - 66'(sx);
    dy = 66'(ey) - 66'(sy);
    ax = 66'(px) - 66'(sx);
    ay = 66'(py) - 66'(sy);
    if (dx == 0 && dy == 0) return dist_t'(hypot_floor(ax, ay));
    dot = ax * dx + ay * dy;
    len2 = dx * dx + dy * dy;
    if (dot <= 0) return dist_t'(hypot_floor(ax, ay));
    if (dot >= len2) return dist_t'(hypot_floor(66'(px) - 66'(ex), 66'(py) - 66'(ey)));
    num = (dot <<< 32) / len2;
    t = num[31:0];
    // arithmetic shift floors toward minus infinity
    prod = $signed({100'd0, t}) * dx;
    hx = 66'(sx) + 66'(prod >>> 32);
    prod = $signed({100'd0, t}) * dy;
    hy = 66'(sy) + 66'(prod >>> 32);
    return dist_t'(hypot_floor(66'(px) - hx, 66'(py) - hy));
  endfunction

  function automatic coord_t rand_coord(input int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($signed($urandom_range(0, 2000)) - 1000);
      2: return $urandom_range(0, 1) ? coord_t'(32'h7fffffff - $urandom_range(0, 3))
                                     : coord_t'(32'h80000000 + $urandom_range(0, 3));
      default: return coord_t'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    endcase
  endfunction

  task automatic send_item(input row_t r, input logic allow_idle);
    int gap;
    if (allow_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_point_x <= r.px; in_point_y <= r.py;
    in_start_x <= r.sx; in_start_y <= r.sy;
    in_end_x <= r.ex; in_end_y <= r.ey;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_dist.push_back(r.known ? r.exp_dist
                                   : seg_distance(r.px, r.py, r.sx, r.sy, r.ex, r.ey));
  endtask

  // result checking
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_dist.size() == 0) begin
        $error("distance: unexpected result %0d", out_distance);
        fail_count++;
      end else begin
        if (out_distance !== pending_dist[0]) begin
          $error("distance: expected %0d actual %0d", pending_dist[0], out_distance);
          fail_count++;
        end
        void'(pending_dist.pop_front());
      end
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  localparam coord_t CMAX = 32'sh7fffffff;
  localparam coord_t CMIN = 32'sh80000000;
  localparam coord_t ONE = 32'sh00010000;
  localparam coord_t TWO = 32'sh00020000;
  localparam coord_t THREE = 32'sh00030000;
  localparam coord_t FOUR = 32'sh00040000;

  row_t directed[] = '{
    // all zero, degenerate
    '{'0, '0, '0, '0, '0, '0, 1'b1, 33'd0},
    // degenerate segment, 3-4-5
    '{THREE, FOUR, '0, '0, '0, '0, 1'b1, 33'd327680},
    // before the start
    '{-THREE, FOUR, '0, '0, FOUR, '0, 1'b1, 33'd327680},
    // past the end
    '{THREE + FOUR, FOUR, '0, '0, FOUR, '0, 1'b1, 33'd327680},
    // foot in the middle
    '{TWO, THREE, '0, '0, FOUR, '0, 1'b1, 33'd196608},
    // point on the start and on the end
    '{ONE, ONE, ONE, ONE, THREE, ONE, 1'b1, 33'd0},
    '{THREE, ONE, ONE, ONE, THREE, ONE, 1'b1, 33'd0},
    // extremes, degenerate corner to corner
    '{CMAX, CMAX, CMIN, CMIN, CMIN, CMIN, 1'b0, '0},
    '{CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, 1'b0, '0},
    '{CMAX, CMIN, CMIN, CMAX, CMIN, CMAX, 1'b0, '0},
    // extreme segments
    '{CMAX, CMIN, CMIN, CMIN, CMAX, CMAX, 1'b0, '0},
    '{CMIN, CMAX, CMIN, CMIN, CMAX, CMAX, 1'b0, '0},
    '{'0, '0, CMIN, CMAX, CMAX, CMIN, 1'b0, '0},
    '{CMAX, CMAX, CMIN, CMIN, CMAX, CMIN, 1'b0, '0},
    // odd slopes, negative direction floors, then a degenerate segment under the point
    '{32'sd5, 32'sd7, '0, '0, -32'sd3, -32'sd11, 1'b0, '0},
    '{-32'sd1, 32'sd1, '0, '0, 32'sd7, -32'sd3, 1'b0, '0},
    '{32'sd1, -32'sd1, 32'sd1, 32'sd1, -32'sd2, 32'sd5, 1'b0, '0},
    '{-32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1, 1'b1, 33'd0}
  };

  initial begin
    row_t r;
    int mode;
    int draw;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed table
    foreach (directed[i]) send_item(directed[i], 1'b1);
    // random items, no idling near the end
    for (int n = 0; n < N_RANDOM; n++) begin
      mode = $urandom_range(0, 3);
      r.known = 1'b0;
      r.exp_dist = '0;
      r.px = rand_coord(mode); r.py = rand_coord(mode);
      r.sx = rand_coord(mode); r.sy = rand_coord(mode);
      draw = $urandom_range(0, 9);
      if (draw == 0) begin
        r.ex = r.sx; r.ey = r.sy;
      end else if (draw == 1) begin
        r.ex = r.sx; r.ey = rand_coord(mode);
      end else begin
        r.ex = rand_coord(mode); r.ey = rand_coord(mode);
      end
      send_item(r, n < N_RANDOM - 200);
    end
    start <= 1'b0;
    while (pending_dist.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire

### sim.f
rtl/core/psd_pkg.sv
rtl/core/point_segment_distance_core.sv
bench/tb_point_segment_distance_core.sv
